/* src/pixel_write_coalescer_top_macros.svh */
// Assertion macros for the pixel write coalescer checker.
`ifndef PIXEL_WRITE_COALESCER_TOP_MACROS_SVH
`define PIXEL_WRITE_COALESCER_TOP_MACROS_SVH

// Same-cycle implication.
`define PWC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pwc: same-cycle check failed");

// Next-cycle implication.
`define PWC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pwc: next-cycle check failed");

`endif

/* src/pwc_pkg.sv */
// Shared types and constants of the pixel write coalescer.
`default_nettype none
package pwc_pkg;

   localparam int X_W       = 11;
   localparam int COLOUR_W  = 16;
   localparam int WORD_W    = 32;
   localparam int COUNT_W   = 9;
   localparam int BYTES_W   = 9;
   localparam int IDX_W     = 6;

   localparam int DEF_BUFFER_WORDS = 32;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   localparam logic MODE_RGB16 = 1'b0;
   localparam logic MODE_PAL8  = 1'b1;

   typedef struct packed {
      logic               valid;
      logic [X_W-1:0]     row;
      logic [X_W-1:0]     start_x;
      logic [BYTES_W-1:0] bytes;
   } burst_req_type;

endpackage
`default_nettype wire

/* src/pwc_req_if.sv */
// Pixel item channel.
`default_nettype none
interface pwc_req_if;
   import pwc_pkg::*;

   logic                valid;
   logic                ready;
   logic                kind;
   logic [X_W-1:0]      pixel_x;
   logic [X_W-1:0]      pixel_y;
   logic [COLOUR_W-1:0] colour;

   modport source (output valid, kind, pixel_x, pixel_y, colour, input ready);
   modport sink   (input valid, kind, pixel_x, pixel_y, colour, output ready);
endinterface
`default_nettype wire

/* src/pwc_rsp_if.sv */
// Burst word channel.
`default_nettype none
interface pwc_rsp_if;
   import pwc_pkg::*;

   logic               valid;
   logic               ready;
   logic [X_W-1:0]     run_row;
   logic [X_W-1:0]     run_start_x;
   logic [BYTES_W-1:0] run_bytes;
   logic [IDX_W-1:0]   word_index;
   logic [WORD_W-1:0]  data_word;
   logic               last_word;

   modport source (output valid, run_row, run_start_x, run_bytes, word_index, data_word,
                   last_word, input ready);
   modport sink   (input valid, run_row, run_start_x, run_bytes, word_index, data_word,
                   last_word, output ready);
endinterface
`default_nettype wire

/* src/pixel_write_coalescer_top.sv */
// Pixel write coalescer: packs pixel runs into a word buffer and bursts them out.
// A continuing pixel is taken every cycle while input is not stalled; it is written into
// the buffer in the same cycle. A burst stalls input while its words are read (longer under
// output stalls); a run-ending pixel stalls it again after the burst to place its first word.
// Burst words appear in the cycle after their buffer read, one per cycle while accepted.
// Synchronous active-high reset clears the run, mode and burst state; no memory clear.
`default_nettype none
module pixel_write_coalescer_top #(
   parameter int BUFFER_WORDS = pwc_pkg::DEF_BUFFER_WORDS
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  csr_wr_en,
   input  wire logic  csr_wr_data,
   pwc_req_if.sink    req_if,
   pwc_rsp_if.source  rsp_if
);
   import pwc_pkg::*;

   localparam int AW = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;

   burst_req_type     burst_req;
   logic              burst_busy;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [WORD_W-1:0] mem_wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [WORD_W-1:0] rd_data;

   pwc_run_ctrl #(
      .BUFFER_WORDS (BUFFER_WORDS),
      .AW           (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (req_if.valid),
      .item_ready  (req_if.ready),
      .kind        (req_if.kind),
      .pixel_x     (req_if.pixel_x),
      .pixel_y     (req_if.pixel_y),
      .colour      (req_if.colour),
      .burst_busy  (burst_busy),
      .burst_req   (burst_req),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   pwc_word_mem #(
      .DEPTH (BUFFER_WORDS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pwc_burst #(
      .BUFFER_WORDS (BUFFER_WORDS),
      .AW           (AW)
   ) u_burst (
      .clock       (clock),
      .reset       (reset),
      .burst_req   (burst_req),
      .burst_busy  (burst_busy),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .out_ready   (rsp_if.ready),
      .out_valid   (rsp_if.valid),
      .out_row     (rsp_if.run_row),
      .out_start_x (rsp_if.run_start_x),
      .out_bytes   (rsp_if.run_bytes),
      .out_index   (rsp_if.word_index),
      .out_last    (rsp_if.last_word)
   );

   assign rsp_if.data_word = rd_data;

endmodule
`default_nettype wire

/* src/pwc_word_mem.sv */
// Run buffer word memory, one write and one registered read port.
`default_nettype none
module pwc_word_mem #(
   parameter int DEPTH = pwc_pkg::DEF_BUFFER_WORDS,
   parameter int AW    = 5
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic [pwc_pkg::WORD_W-1:0] wr_data,
   input  wire logic                      rd_en,
   input  wire logic [AW-1:0]             rd_addr,
   output logic      [pwc_pkg::WORD_W-1:0] rd_data
);
   import pwc_pkg::*;

   logic [WORD_W-1:0] words_mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         words_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= words_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* src/pwc_run_ctrl.sv */
// Run tracking, pixel packing and buffer writes.
`default_nettype none
module pwc_run_ctrl #(
   parameter int BUFFER_WORDS = pwc_pkg::DEF_BUFFER_WORDS,
   parameter int AW           = 5
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic                          csr_wr_data,
   input  wire logic                          item_valid,
   output logic                               item_ready,
   input  wire logic                          kind,
   input  wire logic [pwc_pkg::X_W-1:0]       pixel_x,
   input  wire logic [pwc_pkg::X_W-1:0]       pixel_y,
   input  wire logic [pwc_pkg::COLOUR_W-1:0]  colour,
   input  wire logic                          burst_busy,
   output pwc_pkg::burst_req_type             burst_req,
   output logic                               mem_wr_en,
   output logic      [AW-1:0]                 mem_wr_addr,
   output logic      [pwc_pkg::WORD_W-1:0]    mem_wr_data
);
   import pwc_pkg::*;

   localparam logic [COUNT_W-1:0] CAP16 = COUNT_W'(BUFFER_WORDS * 2);
   localparam logic [COUNT_W-1:0] CAP8  = COUNT_W'(BUFFER_WORDS * 4);

   logic               mode_ff, mode_in;
   logic               run_valid_ff, run_valid_in;
   logic               pend_ff, pend_in;
   logic               rmode_ff, rmode_in;
   logic [X_W-1:0]     row_ff, row_in;
   logic [X_W-1:0]     start_ff, start_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [WORD_W-1:0]  acc_ff, acc_in;

   logic               accept;
   logic               cont;
   logic               full;
   logic [COUNT_W-1:0] new_count;
   logic [COUNT_W-1:0] emit_count;
   logic [COUNT_W-1:0] widx_full;
   logic [WORD_W-1:0]  merged;
   logic [WORD_W-1:0]  first_word;

   assign item_ready = !burst_busy && !pend_ff;
   assign accept     = item_valid && item_ready;

   assign cont = (kind == KIND_PIXEL) && run_valid_ff && (row_ff == pixel_y)
                 && (rmode_ff == mode_ff)
                 && ((12'(start_ff) + 12'(count_ff)) == 12'(pixel_x));

   assign new_count  = count_ff + COUNT_W'(1);
   assign full       = new_count == ((mode_ff == MODE_PAL8) ? CAP8 : CAP16);
   assign emit_count = cont ? new_count : count_ff;
   assign first_word = (mode_ff == MODE_PAL8) ? WORD_W'(colour[7:0]) : WORD_W'(colour);

   always_comb begin
      if (mode_ff == MODE_PAL8) begin
         widx_full = count_ff >> 2;
         if (count_ff[1:0] == 2'd0) begin
            merged = WORD_W'(colour[7:0]);
         end else begin
            merged = acc_ff | (WORD_W'(colour[7:0]) << {count_ff[1:0], 3'b000});
         end
      end else begin
         widx_full = count_ff >> 1;
         merged    = count_ff[0] ? {colour, acc_ff[15:0]} : WORD_W'(colour);
      end
   end

   always_comb begin
      burst_req.valid   = accept && ((cont && full) || (!cont && run_valid_ff));
      burst_req.row     = row_ff;
      burst_req.start_x = start_ff;
      burst_req.bytes   = (rmode_ff == MODE_PAL8) ? emit_count : (emit_count << 1);
   end

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = acc_ff;
      priority if (pend_ff && !burst_busy) begin
         mem_wr_en = 1'b1;
      end else if (accept && cont) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = widx_full[AW-1:0];
         mem_wr_data = merged;
      end else if (accept && (kind == KIND_PIXEL) && !run_valid_ff) begin
         mem_wr_en   = 1'b1;
         mem_wr_data = first_word;
      end else begin
         mem_wr_en = 1'b0;
      end
   end

   always_comb begin
      mode_in      = csr_wr_en ? csr_wr_data : mode_ff;
      run_valid_in = run_valid_ff;
      pend_in      = pend_ff && burst_busy;
      rmode_in     = rmode_ff;
      row_in       = row_ff;
      start_in     = start_ff;
      count_in     = count_ff;
      acc_in       = acc_ff;
      if (accept) begin
         priority if (cont) begin
            count_in = new_count;
            acc_in   = merged;
            if (full) begin
               run_valid_in = 1'b0;
            end
         end else if (kind == KIND_FLUSH) begin
            run_valid_in = 1'b0;
         end else begin
            // new run; word 0 waits until the old burst has been read
            run_valid_in = 1'b1;
            pend_in      = run_valid_ff;
            rmode_in     = mode_ff;
            row_in       = pixel_y;
            start_in     = pixel_x;
            count_in     = COUNT_W'(1);
            acc_in       = first_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RGB16;
         run_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         rmode_ff     <= MODE_RGB16;
         count_ff     <= '0;
      end else begin
         mode_ff      <= mode_in;
         run_valid_ff <= run_valid_in;
         pend_ff      <= pend_in;
         rmode_ff     <= rmode_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff   <= row_in;
      start_ff <= start_in;
      acc_ff   <= acc_in;
   end

endmodule
`default_nettype wire

/* src/pwc_burst.sv */
// Burst read sequencer and output register.
`default_nettype none
module pwc_burst #(
   parameter int BUFFER_WORDS = pwc_pkg::DEF_BUFFER_WORDS,
   parameter int AW           = 5
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pwc_pkg::burst_req_type       burst_req,
   output logic                              burst_busy,
   output logic                              rd_en,
   output logic      [AW-1:0]                rd_addr,
   input  wire logic                         out_ready,
   output logic                              out_valid,
   output logic      [pwc_pkg::X_W-1:0]      out_row,
   output logic      [pwc_pkg::X_W-1:0]      out_start_x,
   output logic      [pwc_pkg::BYTES_W-1:0]  out_bytes,
   output logic      [pwc_pkg::IDX_W-1:0]    out_index,
   output logic                              out_last
);
   import pwc_pkg::*;

   localparam int CW = $clog2(BUFFER_WORDS + 1);

   logic               active_ff, active_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      words_ff, words_in;
   logic [X_W-1:0]     row_ff, row_in;
   logic [X_W-1:0]     sx_ff, sx_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic               ovalid_ff, ovalid_in;
   logic [X_W-1:0]     orow_ff, orow_in;
   logic [X_W-1:0]     osx_ff, osx_in;
   logic [BYTES_W-1:0] obytes_ff, obytes_in;
   logic [IDX_W-1:0]   oidx_ff, oidx_in;
   logic               olast_ff, olast_in;

   logic               issue;
   logic [CW-1:0]      next_idx;
   logic [9:0]         words_full;

   assign issue      = active_ff && (!ovalid_ff || out_ready);
   assign next_idx   = idx_ff + CW'(1);
   assign words_full = (10'(burst_req.bytes) + 10'd3) >> 2;

   assign burst_busy = active_ff;
   assign rd_en      = issue;
   assign rd_addr    = idx_ff[AW-1:0];

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      words_in  = words_ff;
      row_in    = row_ff;
      sx_in     = sx_ff;
      bytes_in  = bytes_ff;
      ovalid_in = ovalid_ff && !out_ready;
      orow_in   = orow_ff;
      osx_in    = osx_ff;
      obytes_in = obytes_ff;
      oidx_in   = oidx_ff;
      olast_in  = olast_ff;
      if (burst_req.valid) begin
         active_in = 1'b1;
         idx_in    = '0;
         words_in  = CW'(words_full);
         row_in    = burst_req.row;
         sx_in     = burst_req.start_x;
         bytes_in  = burst_req.bytes;
      end else if (issue) begin
         idx_in    = next_idx;
         active_in = next_idx != words_ff;
         ovalid_in = 1'b1;
         orow_in   = row_ff;
         osx_in    = sx_ff;
         obytes_in = bytes_ff;
         oidx_in   = IDX_W'(idx_ff);
         olast_in  = next_idx == words_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         ovalid_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         ovalid_ff <= ovalid_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      words_ff  <= words_in;
      row_ff    <= row_in;
      sx_ff     <= sx_in;
      bytes_ff  <= bytes_in;
      orow_ff   <= orow_in;
      osx_ff    <= osx_in;
      obytes_ff <= obytes_in;
      oidx_ff   <= oidx_in;
      olast_ff  <= olast_in;
   end

   assign out_valid   = ovalid_ff;
   assign out_row     = orow_ff;
   assign out_start_x = osx_ff;
   assign out_bytes   = obytes_ff;
   assign out_index   = oidx_ff;
   assign out_last    = olast_ff;

endmodule
`default_nettype wire

/* src/pwc_checker.sv */
// Port-level checks of the pixel write coalescer, bound to the top level.
`default_nettype none
`include "pixel_write_coalescer_top_macros.svh"
module pwc_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [pwc_pkg::BYTES_W-1:0]  rsp_run_bytes,
   input wire logic [pwc_pkg::IDX_W-1:0]    rsp_word_index,
   input wire logic                         rsp_last_word
);
   import pwc_pkg::*;

   // a taken non-final word is followed at once by the next one
   `PWC_ASSERT_NEXT(a_burst_gapless, clock, reset, rsp_valid && rsp_ready && !rsp_last_word, rsp_valid && (rsp_word_index == $past(rsp_word_index) + 6'd1))

   // input stays stalled until the final word is on its way
   `PWC_ASSERT_SAME(a_stall_in_burst, clock, reset, rsp_valid && !rsp_last_word, !req_ready)

   // final word index matches the byte count
   `PWC_ASSERT_SAME(a_last_matches_bytes, clock, reset, rsp_valid && rsp_last_word, ((10'(rsp_run_bytes) + 10'd3) >> 2) == (10'(rsp_word_index) + 10'd1))

   `PWC_ASSERT_SAME(a_bytes_nonzero, clock, reset, rsp_valid, rsp_run_bytes != '0)

endmodule

bind pixel_write_coalescer_top pwc_checker u_pwc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_run_bytes  (rsp_if.run_bytes),
   .rsp_word_index (rsp_if.word_index),
   .rsp_last_word  (rsp_if.last_word)
);
`default_nettype wire

/* bench/tb_pixel_write_coalescer_top.sv */
// Self-checking testbench for the pixel write coalescer: pixel runs, flushes, mode changes.
module tb_pixel_write_coalescer_top;
   import pwc_pkg::*;

   localparam int BUF_WORDS     = DEF_BUFFER_WORDS;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 17;

   typedef struct {
      logic [X_W-1:0]     row;
      logic [X_W-1:0]     start_x;
      logic [BYTES_W-1:0] bytes;
      logic [IDX_W-1:0]   index;
      logic [WORD_W-1:0]  data;
      logic               last;
   } burst_word_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   pwc_req_if req_chan();
   pwc_rsp_if rsp_chan();

   pixel_write_coalescer_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_chan),
      .rsp_if      (rsp_chan)
   );

   burst_word_type expected_words[$];
   int fail_count = 0;
   int items_sent = 0;
   bit gaps_on    = 1'b1;

   // Coalescer state as predicted
   logic              mode_q     = MODE_RGB16;
   bit                run_open   = 1'b0;
   logic [X_W-1:0]    run_row_q  = '0;
   logic [X_W-1:0]    run_x_q    = '0;
   int                run_len    = 0;
   logic              run_mode_q = MODE_RGB16;
   logic [WORD_W-1:0] run_store [BUF_WORDS];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20 * 400000);
      $display("Verification failed");
      $finish;
   end

   function automatic int pixels_per_buffer(logic mode);
      return (mode == MODE_PAL8) ? BUF_WORDS * 4 : BUF_WORDS * 2;
   endfunction

   function automatic void emit_burst();
      int nbytes;
      int nwords;
      burst_word_type w;
      if (!run_open) return;
      nbytes = (run_mode_q == MODE_PAL8) ? run_len : run_len * 2;
      nwords = (nbytes + 3) / 4;
      if (nwords > BUF_WORDS) nwords = BUF_WORDS;
      for (int k = 0; k < nwords; k++) begin
         w.row     = run_row_q;
         w.start_x = run_x_q;
         w.bytes   = nbytes[BYTES_W-1:0];
         w.index   = k[IDX_W-1:0];
         w.data    = run_store[k];
         w.last    = (k + 1 == nwords);
         expected_words.push_back(w);
      end
      run_open = 1'b0;
   endfunction

   function automatic void coalesce_item(logic kind, logic [X_W-1:0] x, logic [X_W-1:0] y,
                                         logic [COLOUR_W-1:0] colour);
      int slot;
      int lane;
      if (kind == KIND_FLUSH) begin
         emit_burst();
         return;
      end
      if (run_open && run_row_q == y && run_mode_q == mode_q &&
          int'(run_x_q) + run_len == int'(x) && run_len < pixels_per_buffer(mode_q)) begin
         if (mode_q == MODE_PAL8) begin
            slot = run_len / 4;
            lane = run_len % 4;
            if (lane != 0) run_store[slot] |= {24'd0, colour[7:0]} << (lane * 8);
            else run_store[slot] = {24'd0, colour[7:0]};
         end else begin
            slot = run_len / 2;
            if (run_len % 2 != 0) run_store[slot] |= {colour, 16'd0};
            else run_store[slot] = {16'd0, colour};
         end
         run_len++;
         if (run_len >= pixels_per_buffer(mode_q)) emit_burst();
      end else begin
         emit_burst();
         run_open     = 1'b1;
         run_row_q    = y;
         run_x_q      = x;
         run_len      = 1;
         run_mode_q   = mode_q;
         run_store[0] = (mode_q == MODE_PAL8) ? {24'd0, colour[7:0]} : {16'd0, colour};
      end
   endfunction

   function automatic void check_field(string field, logic [WORD_W-1:0] want,
                                       logic [WORD_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : check_word
      burst_word_type w;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected burst word: row %0d start_x %0d index %0d",
                   rsp_chan.run_row, rsp_chan.run_start_x, rsp_chan.word_index);
            fail_count++;
         end else begin
            w = expected_words.pop_front();
            check_field("run_row", w.row, rsp_chan.run_row);
            check_field("run_start_x", w.start_x, rsp_chan.run_start_x);
            check_field("run_bytes", w.bytes, rsp_chan.run_bytes);
            check_field("word_index", w.index, rsp_chan.word_index);
            check_field("data_word", w.data, rsp_chan.data_word);
            check_field("last_word", w.last, rsp_chan.last_word);
         end
      end
   end

   // Burst word receiver: random stalls, mostly short, a few long
   initial begin : rsp_pacer
      int hold;
      int pick;
      hold = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               rsp_chan.ready <= 1'b1;
               hold = $urandom_range(0, 7);
            end else if (pick < 60) begin
               rsp_chan.ready <= 1'b1;
               hold = $urandom_range(20, 60);
            end else if (pick < 92) begin
               rsp_chan.ready <= 1'b0;
               hold = $urandom_range(0, 2);
            end else begin
               rsp_chan.ready <= 1'b0;
               hold = $urandom_range(8, 25);
            end
         end
      end
   end

   task automatic pace_sender();
      int pick;
      int gap;
      if (!gaps_on) return;
      pick = $urandom_range(0, 99);
      if (pick < 55) gap = 0;
      else if (pick < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 20);
      if (gap == 0) return;
      @(negedge clock);
      req_chan.valid <= 1'b0;
      repeat (gap - 1) @(negedge clock);
   endtask

   task automatic send_item(logic kind, logic [X_W-1:0] x, logic [X_W-1:0] y,
                            logic [COLOUR_W-1:0] colour);
      @(negedge clock);
      req_chan.valid   <= 1'b1;
      req_chan.kind    <= kind;
      req_chan.pixel_x <= x;
      req_chan.pixel_y <= y;
      req_chan.colour  <= colour;
      do @(posedge clock); while (!req_chan.ready);
      coalesce_item(kind, x, y, colour);
      items_sent++;
      pace_sender();
   endtask

   task automatic await_bursts();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(logic mode);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      mode_q = mode;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_directed_runs();
      send_item(KIND_FLUSH, '1, '1, '1);
      send_item(KIND_PIXEL, 0, 0, 16'hFFFF);
      send_item(KIND_PIXEL, 1, 0, 16'h0000);
      send_item(KIND_PIXEL, 2, 0, 16'hA5A5);
      send_item(KIND_FLUSH, 0, 0, 0);
      send_item(KIND_PIXEL, 2047, 2047, 16'h5A5A);
      // column does not wrap into a continuation
      send_item(KIND_PIXEL, 0, 2047, 16'h1234);
      send_item(KIND_PIXEL, 1, 2047, 16'h8001);
      send_item(KIND_PIXEL, 2, 2046, 16'h7FFE);
      send_item(KIND_PIXEL, 4, 2046, 16'hC3C3);
      send_item(KIND_PIXEL, 3, 2046, 16'h3C3C);
      send_item(KIND_FLUSH, 11'h555, 11'h2AA, 16'hFFFF);
      send_item(KIND_FLUSH, 0, 0, 0);
      send_item(KIND_PIXEL, 1023, 1024, 16'h0001);
      send_item(KIND_FLUSH, 0, 0, 0);
   endtask

   task automatic test_mode_switch();
      await_bursts();
      write_mode(MODE_PAL8);
      for (int i = 0; i < 5; i++)
         send_item(KIND_PIXEL, X_W'(100 + i), 7, COLOUR_W'(16'hFF00 | (16'h11 * i)));
      send_item(KIND_FLUSH, 0, 0, 0);
      for (int i = 0; i < 3; i++)
         send_item(KIND_PIXEL, X_W'(10 + i), 3, COLOUR_W'(16'hABCD + i));
      // run left open across the mode change
      await_bursts();
      write_mode(MODE_RGB16);
      send_item(KIND_PIXEL, 13, 3, 16'hBEEF);
      send_item(KIND_PIXEL, 14, 3, 16'hCAFE);
      await_bursts();
      write_mode(MODE_PAL8);
      send_item(KIND_PIXEL, 15, 3, 16'h00FF);
      send_item(KIND_FLUSH, 0, 0, 0);
   endtask

   task automatic test_buffer_full();
      await_bursts();
      write_mode(MODE_RGB16);
      for (int i = 0; i < BUF_WORDS * 2; i++)
         send_item(KIND_PIXEL, X_W'(1984 + i), 9, COLOUR_W'($urandom_range(0, 65535)));
      send_item(KIND_PIXEL, 0, 9, 16'h4321);
   endtask

   task automatic test_random_traffic();
      int stop_at;
      int pick;
      int len;
      logic [X_W-1:0] row;
      logic [X_W-1:0] start;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            await_bursts();
            write_mode(1'($urandom_range(0, 1)));
         end else if (pick < 10) begin
            gaps_on = !gaps_on;
         end else if (pick < 20) begin
            send_item(KIND_PIXEL, X_W'($urandom_range(0, 2047)), X_W'($urandom_range(0, 2047)),
                      COLOUR_W'($urandom_range(0, 65535)));
         end else if (pick < 25) begin
            send_item(KIND_FLUSH, X_W'($urandom_range(0, 2047)), X_W'($urandom_range(0, 2047)),
                      COLOUR_W'($urandom_range(0, 65535)));
         end else begin
            row   = X_W'($urandom_range(0, 2047));
            start = X_W'($urandom_range(0, 2047));
            len   = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 10);
            if (len > stop_at - items_sent) len = stop_at - items_sent;
            for (int i = 0; i < len; i++)
               send_item(KIND_PIXEL, X_W'(start + i), row, COLOUR_W'($urandom_range(0, 65535)));
            if ($urandom_range(0, 2) == 0) send_item(KIND_FLUSH, 0, 0, 0);
         end
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = 1'b0;
      req_chan.valid   = 1'b0;
      req_chan.kind    = KIND_PIXEL;
      req_chan.pixel_x = '0;
      req_chan.pixel_y = '0;
      req_chan.colour  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_runs();
      test_mode_switch();
      test_buffer_full();
      test_random_traffic();

      await_bursts();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
